FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the band level and peak tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define BLPT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
// Check a condition in the same cycle as its trigger.
`define BLPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Check a condition in the cycle after its trigger.
`define BLPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLPT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define BLPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define BLPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/blpt_pkg.sv
// Types, constants and lookup functions of the band level and peak tracker.
package blpt_pkg;

  localparam int NUM_BANDS = 75;
  localparam int BAR_BANDS = 19;
  localparam int BAND_W    = 7;
  localparam int MAG_W     = 8;
  localparam int VAL_W     = 16;
  localparam int SPD_W     = 24;
  localparam int FAC_W     = 9;
  localparam int SEL_W     = 3;
  localparam int ADDR_W    = $clog2(NUM_BANDS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [SPD_W-1:0] SPEED_START = SPD_W'(655);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_FALLOFF = 2'd0,
    REG_PEAK_FALLOFF  = 2'd1,
    REG_BARS_MODE     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0] level;
    logic [VAL_W-1:0] peak;
    logic [SPD_W-1:0] speed;
  } band_state_t;

  // Level fall step, 1.8; selectors above four act as four.
  function automatic logic [FAC_W-1:0] level_step(input logic [SEL_W-1:0] sel);
    logic [FAC_W-1:0] st;
    case (sel)
      3'd0:    st = FAC_W'(87);
      3'd1:    st = FAC_W'(128);
      3'd2:    st = FAC_W'(256);
      3'd3:    st = FAC_W'(333);
      default: st = FAC_W'(410);
    endcase
    return st;
  endfunction

  // Peak speed growth factor, 1.8; selectors above four act as four.
  function automatic logic [FAC_W-1:0] growth_factor(input logic [SEL_W-1:0] sel);
    logic [FAC_W-1:0] gf;
    case (sel)
      3'd0:    gf = FAC_W'(307);
      3'd1:    gf = FAC_W'(333);
      3'd2:    gf = FAC_W'(358);
      3'd3:    gf = FAC_W'(384);
      default: gf = FAC_W'(410);
    endcase
    return gf;
  endfunction

endpackage

FILE: rtl/core/blpt_update.sv
// Per-band update of level, peak and peak fall speed for one sample.
module blpt_update (
  input  blpt_pkg::band_state_t       cur_state,
  input  logic [blpt_pkg::MAG_W-1:0]  magnitude,
  input  logic [blpt_pkg::SEL_W-1:0]  level_falloff_sel,
  input  logic [blpt_pkg::SEL_W-1:0]  peak_falloff_sel,
  output blpt_pkg::band_state_t       new_state
);
  import blpt_pkg::*;

  logic [VAL_W-1:0]       mag_fx;
  logic                   rise;
  logic [FAC_W-1:0]       step;
  logic [VAL_W-1:0]       level_dec;
  logic [VAL_W-1:0]       level_nxt;
  logic [VAL_W-1:0]       drop;
  logic [VAL_W:0]         peak_diff;
  logic [VAL_W-1:0]       peak_fallen;
  logic [SPD_W+FAC_W-1:0] speed_prod;
  logic [SPD_W:0]         speed_grown;
  logic [SPD_W-1:0]       speed_fallen;

  assign mag_fx = {magnitude, 8'h00};
  assign rise   = mag_fx > cur_state.level;
  assign step   = level_step(level_falloff_sel);

  // Saturating decrement toward zero.
  assign level_dec = (cur_state.level > VAL_W'(step)) ?
                     cur_state.level - VAL_W'(step) : '0;
  assign level_nxt = rise ? mag_fx : level_dec;

  // Peak falls by the speed's integer part, held at or above the new level.
  assign drop        = cur_state.speed[SPD_W-1:8];
  assign peak_diff   = {1'b0, cur_state.peak} - {1'b0, drop};
  assign peak_fallen = (peak_diff[VAL_W] || (peak_diff[VAL_W-1:0] < level_nxt)) ?
                       level_nxt : peak_diff[VAL_W-1:0];

  // Grow speed by the factor, truncate the 8 fraction bits, saturate.
  assign speed_prod   = cur_state.speed * growth_factor(peak_falloff_sel);
  assign speed_grown  = speed_prod[SPD_W+FAC_W-1:8];
  assign speed_fallen = speed_grown[SPD_W] ? '1 : speed_grown[SPD_W-1:0];

  always_comb begin
    new_state.level = level_nxt;
    new_state.peak  = cur_state.peak;
    new_state.speed = cur_state.speed;
    if (rise && (level_nxt > cur_state.peak)) begin
      new_state.peak  = level_nxt;
      new_state.speed = SPEED_START;
    end else if (cur_state.peak != '0) begin
      new_state.peak  = peak_fallen;
      new_state.speed = speed_fallen;
    end
  end

endmodule

FILE: rtl/core/band_level_peak_tracker.sv
// Top level of the band level and peak tracker: handshakes, band store, result register.
// A word accepted into the input regs then moves to the result regs, which drive out_tdata.
// Throughput: one word per cycle unless stalled; the band store read/update/write loop
//   closes through a write-back bypass register, so the same band may arrive back to back.
// Reset: rst_n low at a clock edge clears all band valid bits (every band reads as zero)
//   and the configuration registers; no clearing sweep is needed.
`include "assert_macros.svh"
module band_level_peak_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blpt_pkg::CFG_DAT_W-1:0]   cfg_data,
  // Sample stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [6:0] band, [14:7] magnitude
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata   // [6:0] band_out, [22:7] level_out,
                                                       // [38:23] peak_out
);
  import blpt_pkg::*;

  // Configuration registers
  logic [SEL_W-1:0] level_sel_r;
  logic [SEL_W-1:0] peak_sel_r;
  logic             bars_mode_r;

  // Stage 1: accepted sample plus registered store read
  logic              s1_vld_r;
  logic [BAND_W-1:0] s1_band_r;
  logic [MAG_W-1:0]  s1_mag_r;
  logic              s1_adv;
  logic              s1_in_range;
  logic              s1_hold;
  logic              in_accept;
  logic [BAND_W-1:0] in_band;
  logic [MAG_W-1:0]  in_mag;
  logic              in_range;

  // Band store with one valid bit per band
  band_state_t       state_mem [NUM_BANDS];
  logic [NUM_BANDS-1:0] band_vld_r;
  band_state_t       rd_data_r;
  logic              rd_vld_r;
  logic              wr_en;
  logic [ADDR_W-1:0] s1_addr;

  // Write-back bypass
  logic              wb_vld_r;
  logic [ADDR_W-1:0] wb_addr_r;
  band_state_t       wb_state_r;

  band_state_t       cur_state;
  band_state_t       new_state;

  // Result register
  logic              out_vld_r;
  logic [BAND_W-1:0] out_band_r;
  logic [VAL_W-1:0]  out_level_r;
  logic [VAL_W-1:0]  out_peak_r;
  logic [VAL_W-1:0]  res_level;
  logic [VAL_W-1:0]  res_peak;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, unknown indexes drop silently.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_sel_r <= '0;
      peak_sel_r  <= '0;
      bars_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEVEL_FALLOFF: level_sel_r <= cfg_data[SEL_W-1:0];
        REG_PEAK_FALLOFF:  peak_sel_r  <= cfg_data[SEL_W-1:0];
        REG_BARS_MODE:     bars_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: take a word whenever stage 1 is empty or moving on.
  // ---------------------------------------------------------------------------
  assign in_band   = in_tdata[BAND_W-1:0];
  assign in_mag    = in_tdata[BAND_W+MAG_W-1:BAND_W];
  assign in_range  = in_band < BAND_W'(NUM_BANDS);
  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_band_r <= in_band;
      s1_mag_r  <= in_mag;
    end
  end

  // ---------------------------------------------------------------------------
  // Band store: read on accept, write when the updated word leaves stage 1.
  // ---------------------------------------------------------------------------
  assign s1_addr     = s1_band_r[ADDR_W-1:0];
  assign s1_in_range = s1_band_r < BAND_W'(NUM_BANDS);
  // Bars mode leaves the upper bands untouched and echoes what is stored.
  assign s1_hold     = bars_mode_r && (s1_band_r >= BAND_W'(BAR_BANDS));
  assign wr_en       = s1_vld_r && s1_adv && s1_in_range && !s1_hold;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[s1_addr] <= new_state;
    end
    if (in_accept && in_range) begin
      rd_data_r <= state_mem[in_band[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      wb_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        band_vld_r[s1_addr] <= 1'b1;
      end
      if (in_accept && in_range) begin
        rd_vld_r <= band_vld_r[in_band[ADDR_W-1:0]];
      end
      if (wr_en) begin
        wb_vld_r <= 1'b1;
      end
    end
  end

  // Hold the last write so a read that raced it sees the fresh value.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr_r  <= s1_addr;
      wb_state_r <= new_state;
    end
  end

  always_comb begin
    if (wb_vld_r && (wb_addr_r == s1_addr)) begin
      cur_state = wb_state_r;
    end else if (rd_vld_r) begin
      cur_state = rd_data_r;
    end else begin
      cur_state = '0;
    end
  end

  blpt_update u_update (
    .cur_state         (cur_state),
    .magnitude         (s1_mag_r),
    .level_falloff_sel (level_sel_r),
    .peak_falloff_sel  (peak_sel_r),
    .new_state         (new_state)
  );

  // ---------------------------------------------------------------------------
  // Result register: out-of-store bands report zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (!s1_in_range) begin
      res_level = '0;
      res_peak  = '0;
    end else if (s1_hold) begin
      res_level = cur_state.level;
      res_peak  = cur_state.peak;
    end else begin
      res_level = new_state.level;
      res_peak  = new_state.peak;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_band_r  <= s1_band_r;
      out_level_r <= res_level;
      out_peak_r  <= res_peak;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_peak_r, out_level_r, out_band_r};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BLPT_ASSERT_SAME(a_peak_covers_level, clk, rst_n,
                    out_vld_r, out_level_r <= out_peak_r, "peak below level")
  `BLPT_ASSERT_SAME(a_write_in_store, clk, rst_n,
                    wr_en, s1_vld_r && s1_in_range, "store write without in-range word")
  `BLPT_ASSERT_NEXT(a_stage_moves, clk, rst_n,
                    s1_vld_r && s1_adv, out_vld_r, "stage 1 word lost")
  `BLPT_ASSERT_NEXT(a_stall_holds_result, clk, rst_n,
                    out_vld_r && !out_tready, out_vld_r && $stable(out_tdata),
                    "result word changed during stall")

endmodule

FILE: test/tb_top.sv
// Self-checking stream testbench for the band level and peak tracker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import blpt_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The longest quiet
  // stretch comes from the deliberate result hold-off.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_ITEMS   = 900;
  localparam int PHASE_ITEMS    = 150;
  localparam int DRAIN_CYCLES   = 8;

  // Index 3 of the register port maps to no register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [SPD_W-1:0] SPEED_SAT = '1;
  localparam logic [VAL_W-1:0] FULL_SCALE = 16'hFF00;

  // Level fall steps (1.8) and speed growth factors (1.8), entry 0 in the low bits.
  localparam logic [4:0][FAC_W-1:0] FALL_STEPS     = {9'd410, 9'd333, 9'd256, 9'd128, 9'd87};
  localparam logic [4:0][FAC_W-1:0] GROWTH_FACTORS = {9'd410, 9'd384, 9'd358, 9'd333, 9'd307};

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [VAL_W-1:0]  level;
    logic [VAL_W-1:0]  peak;
  } band_result_t;

  // A result typed into the directed table overrides the computed one.
  typedef struct packed {
    logic         fixed;
    band_result_t res;
  } known_result_t;

  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    logic [BAND_W-1:0]    band;
    logic [MAG_W-1:0]     mag;
    logic                 fixed;
    logic [VAL_W-1:0]     level;
    logic [VAL_W-1:0]     peak;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // [6:0] band, [14:7] magnitude, [15] zero
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;         // [6:0] band_out, [22:7] level_out,
                                           // [38:23] peak_out

  // Shadow of the block's band store and registers.
  logic [VAL_W-1:0] lvl_store   [NUM_BANDS] = '{default: '0};
  logic [VAL_W-1:0] peak_store  [NUM_BANDS] = '{default: '0};
  logic [SPD_W-1:0] speed_store [NUM_BANDS] = '{default: '0};
  logic [SEL_W-1:0] lvl_sel  = '0;
  logic [SEL_W-1:0] peak_sel = '0;
  logic             bars_cfg = 1'b0;

  band_result_t  levels_due [$];   // results owed by the block, oldest first
  known_result_t known_levels [$]; // one entry per offered word, typed or not
  stim_row_t     dir_rows [$];

  int   errors       = 0;
  int   quiet_cycles = 0;
  int   applied      = 0;  // random words offered so far
  bit   no_gaps      = 1'b0;
  bit   hold_off_req = 1'b0;

  band_level_peak_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Band tracker prediction
  // ---------------------------------------------------------------------------

  // Selectors above four behave as four.
  function automatic int clip_sel(input logic [SEL_W-1:0] s);
    return (s > 3'd4) ? 4 : int'(s);
  endfunction

  // Drop the peak by its speed, floor it at the level, then grow the speed.
  function automatic void decay_peak(input int b);
    int          p;
    logic [33:0] grown;
    p = int'(peak_store[b]) - int'(speed_store[b] >> 8);
    grown = (34'(speed_store[b]) * 34'(GROWTH_FACTORS[clip_sel(peak_sel)])) >> 8;
    speed_store[b] = (grown > 34'(SPEED_SAT)) ? SPEED_SAT : grown[SPD_W-1:0];
    if (p < int'(lvl_store[b])) p = int'(lvl_store[b]);
    if (p < 0) p = 0;
    peak_store[b] = p[VAL_W-1:0];
  endfunction

  function automatic band_result_t track_band(input logic [BAND_W-1:0] b,
                                              input logic [MAG_W-1:0] mag);
    band_result_t     r;
    logic [VAL_W-1:0] m16;
    logic [VAL_W-1:0] st;
    r.band  = b;
    r.level = '0;
    r.peak  = '0;
    m16 = {mag, 8'h00};
    // Bands past the store read as zero and change nothing.
    if (int'(b) < NUM_BANDS) begin
      // In bars mode the upper bands only echo what they hold.
      if (!(bars_cfg && int'(b) >= BAR_BANDS)) begin
        if (m16 > lvl_store[b]) begin
          lvl_store[b] = m16;
          if (lvl_store[b] > peak_store[b]) begin
            peak_store[b]  = lvl_store[b];
            speed_store[b] = SPEED_START;
          end else if (peak_store[b] != '0) begin
            decay_peak(int'(b));
          end
        end else begin
          if (lvl_store[b] != '0) begin
            st = VAL_W'(FALL_STEPS[clip_sel(lvl_sel)]);
            lvl_store[b] = (lvl_store[b] > st) ? lvl_store[b] - st : '0;
          end
          if (peak_store[b] != '0) decay_peak(int'(b));
        end
      end
      r.level = lvl_store[b];
      r.peak  = peak_store[b];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: track register writes, predict on accepted samples, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    band_result_t  got;
    band_result_t  want;
    known_result_t spot;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVEL_FALLOFF: lvl_sel  = cfg_data[SEL_W-1:0];
          REG_PEAK_FALLOFF:  peak_sel = cfg_data[SEL_W-1:0];
          REG_BARS_MODE:     bars_cfg = cfg_data[0];
          default: ;
        endcase
      end
      // Check the result word before queuing a new expectation: results are registered,
      // so this word can never belong to a sample taken now.
      if (out_tvalid && out_tready) begin
        got.band  = out_tdata[6:0];
        got.level = out_tdata[22:7];
        got.peak  = out_tdata[38:23];
        if (levels_due.size() == 0) begin
          errors++;
          $display("%0t: result word %h with no result expected", $time, out_tdata);
        end else begin
          want = levels_due.pop_front();
          if (got.band !== want.band) begin
            errors++;
            $display("%0t: band_out expected %0d, got %0d", $time, want.band, got.band);
          end
          if (got.level !== want.level) begin
            errors++;
            $display("%0t: band %0d level_out expected %h, got %h",
                     $time, want.band, want.level, got.level);
          end
          if (got.peak !== want.peak) begin
            errors++;
            $display("%0t: band %0d peak_out expected %h, got %h",
                     $time, want.band, want.peak, got.peak);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        spot = known_levels.pop_front();
        want = track_band(in_tdata[6:0], in_tdata[14:7]);
        levels_due.push_back(spot.fixed ? spot.res : want);
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (no_gaps || $urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        // Mostly short stalls, now and then a long one.
        out_tready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? int'($urandom_range(15, 60)) - 1
                                            : int'($urandom_range(0, 2));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly random magnitudes, with silence and full scale showing up often.
  function automatic logic [MAG_W-1:0] pick_mag();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return '1;
    return MAG_W'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t row_sample(input logic [BAND_W-1:0] b,
                                           input logic [MAG_W-1:0] m);
    stim_row_t r;
    r = '0;
    r.band = b;
    r.mag  = m;
    return r;
  endfunction

  function automatic stim_row_t row_known(input logic [BAND_W-1:0] b,
                                          input logic [MAG_W-1:0] m,
                                          input logic [VAL_W-1:0] lvl,
                                          input logic [VAL_W-1:0] pk);
    stim_row_t r;
    r = row_sample(b, m);
    r.fixed = 1'b1;
    r.level = lvl;
    r.peak  = pk;
    return r;
  endfunction

  // Offer one sample word and hold it until accepted. Valid stays high on exit so
  // a back-to-back caller simply replaces the data in the same step.
  task automatic offer_sample(input logic [BAND_W-1:0] b, input logic [MAG_W-1:0] m,
                              input logic fixed, input logic [VAL_W-1:0] lvl,
                              input logic [VAL_W-1:0] pk);
    int            gap;
    known_result_t spot;
    gap = sender_gap();
    spot.fixed     = fixed;
    spot.res.band  = b;
    spot.res.level = lvl;
    spot.res.peak  = pk;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    known_levels.push_back(spot);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, m, b};
    do @(posedge clk); while (!in_tready);
  endtask

  // Every random sample counts toward the total, wherever it lands.
  task automatic offer_random(input logic [BAND_W-1:0] b, input logic [MAG_W-1:0] m);
    offer_sample(b, m, 1'b0, '0, '0);
    applied++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int               phase;
    int               phase_start;
    int               last;
    int               burst_len;
    int               style;
    int               k;
    logic [BAND_W-1:0] b;
    logic [MAG_W-1:0]  m;
    logic [SEL_W-1:0]  lsel;
    logic [SEL_W-1:0]  psel;
    logic              bars;

    // Directed part. Runs from reset with both selectors at zero and bars mode off.
    dir_rows = '{
      row_known(0, 0, 16'h0000, 16'h0000),         // empty band stays empty
      row_known(74, 0, 16'h0000, 16'h0000),        // top band after reset
      row_known(0, 255, FULL_SCALE, FULL_SCALE),   // full-scale rise sets level and peak
      row_sample(0, 0),                            // level falls, peak starts falling
      row_sample(0, 0),
      row_sample(0, 128),                          // sample below level still falls
      row_known(74, 255, FULL_SCALE, FULL_SCALE),
      row_known(75, 255, 16'h0000, 16'h0000),      // first band past the store
      row_known(127, 255, 16'h0000, 16'h0000),     // largest band index
      row_known(1, 1, 16'h0100, 16'h0100),         // smallest nonzero magnitude
      row_sample(1, 0),                            // walk the level down to zero
      row_sample(1, 0),
      row_sample(1, 0),
      row_sample(1, 0),
      row_reg(REG_LEVEL_FALLOFF, 8'h07),           // selectors above four
      row_reg(REG_PEAK_FALLOFF, 8'hF7),
      row_reg(REG_SPARE, 8'hFF),                   // no register behind this index
      row_known(2, 200, 16'hC800, 16'hC800),
      row_sample(2, 0),
      row_sample(2, 199),                          // rise that stays under the peak
      row_reg(REG_BARS_MODE, 8'hFF),
      row_known(18, 50, 16'h3200, 16'h3200),       // last bar band still updates
      row_known(19, 255, 16'h0000, 16'h0000),      // first band bars mode ignores
      row_known(74, 0, FULL_SCALE, FULL_SCALE),    // ignored band echoes its store
      row_known(100, 9, 16'h0000, 16'h0000),
      row_reg(REG_BARS_MODE, 8'hFE),               // only bit 0 matters
      row_known(19, 255, FULL_SCALE, FULL_SCALE),
      row_sample(0, 0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        offer_sample(dir_rows[i].band, dir_rows[i].mag, dir_rows[i].fixed,
                     dir_rows[i].level, dir_rows[i].peak);
      end
    end

    // Random part, in phases of fixed register settings. The first phases pin the
    // extremes; later ones draw them. Upper data bits are random and must be ignored.
    for (phase = 0; applied < RANDOM_ITEMS; phase++) begin
      settle();
      case (phase)
        0:       begin lsel = 3'd0; psel = 3'd4; bars = 1'b0; end
        1:       begin lsel = 3'd4; psel = 3'd0; bars = 1'b0; end
        2:       begin lsel = 3'd7; psel = 3'd7; bars = 1'b1; end
        default: begin
          lsel = SEL_W'($urandom_range(0, 7));
          psel = SEL_W'($urandom_range(0, 7));
          bars = ($urandom_range(0, 2) == 0);
        end
      endcase
      write_reg(REG_LEVEL_FALLOFF, {5'($urandom), lsel});
      write_reg(REG_PEAK_FALLOFF, {5'($urandom), psel});
      write_reg(REG_BARS_MODE, {7'($urandom), bars});

      // One phase runs back to back and starts with a long result hold-off, so the
      // block fills up and has to stall its input. Every fourth phase has no gaps.
      no_gaps = (phase == 1) || (phase % 4 == 3);
      if (phase == 1) hold_off_req = 1'b1;

      phase_start = applied;
      while (applied - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // Spectrum frame: bands in order from zero.
            last = $urandom_range(BAR_BANDS - 1, NUM_BANDS - 1);
            for (k = 0; k <= last; k++) offer_random(BAND_W'(k), pick_mag());
          end
          5, 6, 7: begin
            // Burst on one band: a steady tone, silence or random magnitudes. Silence grows
            // the speed toward saturation and lets level and peak fall.
            b = BAND_W'($urandom_range(0, NUM_BANDS - 1));
            burst_len = $urandom_range(20, 60);
            style = $urandom_range(0, 2);
            m = MAG_W'($urandom_range(200, 255));
            for (k = 0; k < burst_len; k++) begin
              if (style == 1) m = '0;
              else if (style == 2) m = pick_mag();
              offer_random(b, m);
            end
          end
          default: begin
            // Noise over the whole band field, past the store included.
            for (k = 0; k < 12; k++) offer_random(BAND_W'($urandom_range(0, 127)), pick_mag());
          end
        endcase
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/blpt_pkg.sv
rtl/core/blpt_update.sv
rtl/core/band_level_peak_tracker.sv
test/tb_top.sv
